@@ rtl/core/mqufi_pkg.sv @@
package mqufi_pkg;

   localparam int NUM_QUEUES  = 20;
   localparam int QUEUE_DEPTH = 5;
   localparam int ID_BITS     = 16;

   // fixed port field widths
   localparam int PORT_ID_BITS  = 16;
   localparam int SEL_BITS      = 5;
   localparam int FILL_OUT_BITS = 3;
   localparam int SEL_WIDE_BITS = 7;

   localparam int QIDX_BITS  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int EIDX_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_ONE   = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_DEPTH = COUNT_BITS'(QUEUE_DEPTH);

   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_TAKE = 1'b1;

   typedef enum logic [1:0] {
      RC_ADDED = 2'd0,
      RC_FULL  = 2'd1,
      RC_BAD   = 2'd2,
      RC_TAKEN = 2'd3
   } rc_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SHIFT,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic               urgent;
   } entry_type;

   typedef entry_type [QUEUE_DEPTH-1:0] row_type;

   // one entry move: row[dst] <= use_new ? new_entry : row[src]
   typedef struct packed {
      logic [EIDX_BITS-1:0] dst;
      logic [EIDX_BITS-1:0] src;
      logic                 use_new;
      entry_type            new_entry;
   } step_ctrl_type;

   function automatic logic [ID_BITS-1:0] id_from_port(input logic [PORT_ID_BITS-1:0] p);
      logic [31:0] wide;
      wide = {16'd0, p};
      return wide[ID_BITS-1:0];
   endfunction

   function automatic logic [PORT_ID_BITS-1:0] id_to_port(input logic [ID_BITS-1:0] e);
      logic [31:0] wide;
      wide = '0;
      wide[ID_BITS-1:0] = e;
      return wide[PORT_ID_BITS-1:0];
   endfunction

   function automatic logic [FILL_OUT_BITS-1:0] fill_to_port(input logic [COUNT_BITS-1:0] c);
      logic [7:0] wide;
      wide = '0;
      wide[COUNT_BITS-1:0] = c;
      return wide[FILL_OUT_BITS-1:0];
   endfunction

endpackage

@@ rtl/core/mqufi_if.sv @@
interface mqufi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  func;
   logic [mqufi_pkg::SEL_BITS-1:0]        queue_sel;
   logic [mqufi_pkg::PORT_ID_BITS-1:0]    item_id;
   logic                                  urgent;

   modport source (output valid, func, queue_sel, item_id, urgent, input ready);
   modport sink   (input valid, func, queue_sel, item_id, urgent, output ready);
endinterface

interface mqufi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            result_code;
   logic [mqufi_pkg::PORT_ID_BITS-1:0]    taken_id;
   logic                                  taken_urgent;
   logic [mqufi_pkg::FILL_OUT_BITS-1:0]   fill_after;

   modport source (output valid, result_code, taken_id, taken_urgent, fill_after,
                   input ready);
   modport sink   (input valid, result_code, taken_id, taken_urgent, fill_after,
                   output ready);
endinterface

@@ rtl/core/mqufi_row_step.sv @@
// Shared entry mover: copies one entry of a row (or a fresh entry) to one slot.
module mqufi_row_step (
   input  mqufi_pkg::row_type       row_i,
   input  mqufi_pkg::step_ctrl_type ctrl,
   output mqufi_pkg::row_type       row_o
);

   mqufi_pkg::entry_type src_entry;

   always_comb begin
      src_entry = ctrl.use_new ? ctrl.new_entry : row_i[ctrl.src];
      row_o = row_i;
      row_o[ctrl.dst] = src_entry;
   end

endmodule

@@ rtl/core/multi_queue_urgent_front_insert.sv @@
// Bounded multi-queue with urgent push-front.
// req_chan carries one command word: func (add / take), queue_sel (1..NUM_QUEUES),
// item_id and urgent. rsp_chan returns one word per command: result_code,
// taken_id, taken_urgent and fill_after. Both use valid/ready; a word moves on
// a clock edge where both are high.
// Each queue is one row of the row memory; a command on a valid queue reads the
// row into a working buffer. An add or take that goes ahead edits it one entry
// per cycle through a single shared entry mover, then writes it back. A bad
// queue number goes straight to the response; a full add or an empty take
// skips the edit. A regular add drops the new entry at the tail; an urgent add
// first pushes each entry back by one move, walking from the tail, then drops
// the new entry at the head; a take pulls every entry behind the head forward
// by one slot. req_chan.ready is high only while idle, so the next command can
// be accepted in the cycle after the previous response is loaded. If rsp_chan
// stalls, the next command still runs and waits only at its own response load.
// Reset (synchronous, active high) empties every queue by clearing the fill
// counts and drops any pending response; the row memory is not cleared, only
// entries below a fill count are ever read.
module multi_queue_urgent_front_insert (
   input  logic            clock,
   input  logic            reset,
   mqufi_req_if.sink       req_chan,
   mqufi_rsp_if.source     rsp_chan
);

   // ---------------------------------------------------------------- state
   mqufi_pkg::state_type state_ff, state_in;

   // command fields latched at accept
   logic                                func_ff;
   logic                                urg_ff;
   logic [mqufi_pkg::ID_BITS-1:0]       id_ff;
   logic [mqufi_pkg::QIDX_BITS-1:0]     q_ff;
   logic [mqufi_pkg::COUNT_BITS-1:0]    fill_ff;

   // work registers
   mqufi_pkg::rc_type                   code_ff;
   logic [mqufi_pkg::COUNT_BITS-1:0]    new_fill_ff;
   logic [mqufi_pkg::COUNT_BITS-1:0]    step_ff;
   logic [mqufi_pkg::ID_BITS-1:0]       tid_ff;
   logic                                turg_ff;
   mqufi_pkg::row_type                  row_ff;

   // storage
   mqufi_pkg::row_type                  row_mem [mqufi_pkg::NUM_QUEUES];
   logic [mqufi_pkg::COUNT_BITS-1:0]    fill_cnt_ff [mqufi_pkg::NUM_QUEUES];

   // response register
   logic                                rsp_valid_ff;
   mqufi_pkg::rc_type                   rsp_code_ff;
   logic [mqufi_pkg::PORT_ID_BITS-1:0]  rsp_id_ff;
   logic                                rsp_urg_ff;
   logic [mqufi_pkg::FILL_OUT_BITS-1:0] rsp_fill_ff;

   // ------------------------------------------------------------ decoding
   logic [mqufi_pkg::SEL_WIDE_BITS-1:0] sel_wide;
   logic [mqufi_pkg::SEL_WIDE_BITS-1:0] sel_m1;
   logic [mqufi_pkg::QIDX_BITS-1:0]     sel_idx;
   logic                                sel_ok;
   logic                                req_fire;

   assign sel_wide = mqufi_pkg::SEL_WIDE_BITS'(req_chan.queue_sel);
   assign sel_m1   = sel_wide - mqufi_pkg::SEL_WIDE_BITS'(1);
   assign sel_idx  = sel_m1[mqufi_pkg::QIDX_BITS-1:0];
   assign sel_ok   = (sel_wide != '0) &&
                     (sel_wide <= mqufi_pkg::SEL_WIDE_BITS'(mqufi_pkg::NUM_QUEUES));

   // control outputs
   logic                                req_ready;
   logic                                step_en;
   logic                                commit;
   logic                                rsp_load;
   logic                                shift_last;
   logic [mqufi_pkg::COUNT_BITS-1:0]    step_next;
   mqufi_pkg::step_ctrl_type            step_ctrl;
   mqufi_pkg::row_type                  step_row;

   assign req_fire = req_chan.valid && req_ready;

   // last cycle of the edit pass
   always_comb begin
      if (func_ff == mqufi_pkg::FUNC_TAKE) begin
         shift_last = ((step_ff + mqufi_pkg::COUNT_ONE) >= fill_ff);
      end else if (urg_ff) begin
         shift_last = (step_ff == '0);
      end else begin
         shift_last = 1'b1;
      end
   end

   // ---------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqufi_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = sel_ok ? mqufi_pkg::ST_EVAL : mqufi_pkg::ST_FINISH;
            end
         end
         mqufi_pkg::ST_EVAL: begin
            if (func_ff == mqufi_pkg::FUNC_TAKE) begin
               state_in = (fill_ff == '0) ? mqufi_pkg::ST_FINISH : mqufi_pkg::ST_SHIFT;
            end else begin
               state_in = (fill_ff >= mqufi_pkg::COUNT_DEPTH) ? mqufi_pkg::ST_FINISH
                                                              : mqufi_pkg::ST_SHIFT;
            end
         end
         mqufi_pkg::ST_SHIFT: begin
            if (shift_last) begin
               state_in = mqufi_pkg::ST_COMMIT;
            end
         end
         mqufi_pkg::ST_COMMIT: begin
            state_in = mqufi_pkg::ST_FINISH;
         end
         mqufi_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = mqufi_pkg::ST_IDLE;
            end
         end
         default: state_in = mqufi_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------- outputs
   always_comb begin
      req_ready           = 1'b0;
      step_en             = 1'b0;
      commit              = 1'b0;
      rsp_load            = 1'b0;
      step_next           = step_ff;
      step_ctrl.dst       = step_ff[mqufi_pkg::EIDX_BITS-1:0];
      step_ctrl.src       = step_ff[mqufi_pkg::EIDX_BITS-1:0];
      step_ctrl.use_new   = 1'b0;
      step_ctrl.new_entry = '{id: id_ff, urgent: urg_ff};
      unique case (state_ff)
         mqufi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         mqufi_pkg::ST_SHIFT: begin
            if (func_ff == mqufi_pkg::FUNC_TAKE) begin
               // pull the next entry forward
               if (!shift_last) begin
                  step_en       = 1'b1;
                  step_next     = step_ff + mqufi_pkg::COUNT_ONE;
                  step_ctrl.src = step_next[mqufi_pkg::EIDX_BITS-1:0];
               end
            end else if (urg_ff && !shift_last) begin
               // push one entry back, walking from the tail
               step_en       = 1'b1;
               step_next     = step_ff - mqufi_pkg::COUNT_ONE;
               step_ctrl.src = step_next[mqufi_pkg::EIDX_BITS-1:0];
            end else begin
               // drop the new entry at head (urgent) or tail (regular)
               step_en           = 1'b1;
               step_ctrl.use_new = 1'b1;
            end
         end
         mqufi_pkg::ST_COMMIT: begin
            commit = 1'b1;
         end
         mqufi_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         mqufi_pkg::ST_EVAL: ;
         default: ;
      endcase
   end

   mqufi_row_step u_row_step (
      .row_i (row_ff),
      .ctrl  (step_ctrl),
      .row_o (step_row)
   );

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mqufi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command latch and per-command bookkeeping
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff     <= req_chan.func;
         urg_ff      <= req_chan.urgent;
         id_ff       <= mqufi_pkg::id_from_port(req_chan.item_id);
         q_ff        <= sel_idx;
         fill_ff     <= sel_ok ? fill_cnt_ff[sel_idx] : '0;
         code_ff     <= mqufi_pkg::RC_BAD;
         new_fill_ff <= '0;
         tid_ff      <= '0;
         turg_ff     <= 1'b0;
      end else if (state_ff == mqufi_pkg::ST_EVAL) begin
         // take walks up from the head, add walks down from the fill
         step_ff <= (func_ff == mqufi_pkg::FUNC_TAKE) ? '0 : fill_ff;
         if (func_ff == mqufi_pkg::FUNC_TAKE) begin
            if (fill_ff != '0) begin
               code_ff     <= mqufi_pkg::RC_TAKEN;
               new_fill_ff <= fill_ff - mqufi_pkg::COUNT_ONE;
               tid_ff      <= row_ff[0].id;
               turg_ff     <= row_ff[0].urgent;
            end
         end else if (fill_ff >= mqufi_pkg::COUNT_DEPTH) begin
            code_ff     <= mqufi_pkg::RC_FULL;
            new_fill_ff <= fill_ff;
         end else begin
            code_ff     <= mqufi_pkg::RC_ADDED;
            new_fill_ff <= fill_ff + mqufi_pkg::COUNT_ONE;
         end
      end else if (step_en) begin
         step_ff <= step_next;
      end
   end

   // working row buffer: loaded from memory at accept, edited while shifting
   always_ff @(posedge clock) begin
      if (req_fire && sel_ok) begin
         row_ff <= row_mem[sel_idx];
      end else if (step_en) begin
         row_ff <= step_row;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         row_mem[q_ff] <= row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mqufi_pkg::NUM_QUEUES; i++) begin
            fill_cnt_ff[i] <= '0;
         end
      end else if (commit) begin
         fill_cnt_ff[q_ff] <= new_fill_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_code_ff <= code_ff;
         rsp_id_ff   <= mqufi_pkg::id_to_port(tid_ff);
         rsp_urg_ff  <= turg_ff;
         rsp_fill_ff <= mqufi_pkg::fill_to_port(new_fill_ff);
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_code  = rsp_code_ff;
   assign rsp_chan.taken_id     = rsp_id_ff;
   assign rsp_chan.taken_urgent = rsp_urg_ff;
   assign rsp_chan.fill_after   = rsp_fill_ff;

   // ----------------------------------------------------------- assertions
   // a latched fill count never exceeds the queue depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqufi_pkg::ST_EVAL) |-> (fill_ff <= mqufi_pkg::COUNT_DEPTH))
      else $error("fill count above queue depth");

   // only a take reports an item
   a_taken_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_code_ff != mqufi_pkg::RC_TAKEN))
         |-> ((rsp_id_ff == '0) && !rsp_urg_ff))
      else $error("item reported on a non-take response");

   // a successful add always leaves at least one entry
   a_added_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_code_ff == mqufi_pkg::RC_ADDED)) |-> (rsp_fill_ff != '0))
      else $error("add reported with empty queue");

   // the row is written back only after the edit pass
   a_commit_order: assert property (@(posedge clock) disable iff (reset)
      commit |-> ($past(state_ff) == mqufi_pkg::ST_SHIFT))
      else $error("row written back without an edit pass");

endmodule
